FILE: src/mftt_pkg.sv
// Shared types and fixed constants of the motor feedback turn tracker.
// No dependencies; every other file refers to this package by scoped names.
package mftt_pkg;

    // Frame identifier base: motor slot n answers on BASE_ID + 1 + n
    localparam logic [10:0] BASE_ID   = 11'h200;

    localparam int SLOT_W    = 4;
    localparam int DATA_W    = 16;
    localparam int DELTA_W   = 17;
    localparam int COUNT_W   = 32;
    localparam int THR_W     = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd100;

    // Decoded feedback frame, held in the input register
    typedef struct packed {
        logic                     bus;
        logic [SLOT_W-1:0]        slot;
        logic [DATA_W-1:0]        angle;
        logic signed [DATA_W-1:0] speed;
        logic signed [DATA_W-1:0] current;
    } t_frame;

endpackage

FILE: src/mftt_decode.sv
// Input register stage: filters frame identifiers and buses, decodes the
// big-endian fields and forms the entry index. Depends on mftt_pkg.
module mftt_decode #(
    parameter int MOTORS_PER_BUS = 11,
    parameter int BUS_COUNT      = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic                    i_advance,
    input  logic                    i_bus_select,
    input  logic [10:0]             i_frame_id,
    input  logic [7:0]              i_angle_high,
    input  logic [7:0]              i_angle_low,
    input  logic [7:0]              i_speed_high,
    input  logic [7:0]              i_speed_low,
    input  logic [7:0]              i_current_high,
    input  logic [7:0]              i_current_low,
    output logic                    o_valid,
    output mftt_pkg::t_frame        o_frame,
    output logic [((BUS_COUNT > 2 ? 2 : BUS_COUNT) * MOTORS_PER_BUS > 1 ?
                   $clog2((BUS_COUNT > 2 ? 2 : BUS_COUNT) * MOTORS_PER_BUS) : 1) - 1:0]
                                    o_index
);

    localparam int EFF_BUS = (BUS_COUNT > 2) ? 2 : BUS_COUNT;
    localparam int ENTRIES = EFF_BUS * MOTORS_PER_BUS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [10:0] LAST_ID = mftt_pkg::BASE_ID + 11'(MOTORS_PER_BUS);

    logic                    r_valid;
    mftt_pkg::t_frame        r_frame;
    logic [IDX_W-1:0]        r_index;

    logic                    hit;
    logic [10:0]             id_off;
    logic [mftt_pkg::SLOT_W-1:0] slot;
    logic [5:0]              entry_sum;
    mftt_pkg::t_frame        n_frame;

    // Drop identifiers outside the slot range and buses that are not fitted
    always_comb begin
        id_off    = i_frame_id - mftt_pkg::BASE_ID - 11'd1;
        slot      = id_off[mftt_pkg::SLOT_W-1:0];
        hit       = (i_frame_id > mftt_pkg::BASE_ID) && (i_frame_id <= LAST_ID)
                    && ((BUS_COUNT > 1) || !i_bus_select);
        entry_sum = {2'b00, slot} + (i_bus_select ? 6'(MOTORS_PER_BUS) : 6'd0);
        n_frame.bus     = i_bus_select;
        n_frame.slot    = slot;
        n_frame.angle   = {i_angle_high, i_angle_low};
        n_frame.speed   = {i_speed_high, i_speed_low};
        n_frame.current = {i_current_high, i_current_low};
    end

    // Hold the valid flag until the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= hit;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the decoded payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= n_frame;
            r_index <= entry_sum[IDX_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;
    assign o_index = r_index;

endmodule

FILE: src/mftt_table.sv
// Per-motor state table: last angle and multi-turn count, with the
// read-modify-write of one entry per cycle while i_we is set. Depends on mftt_pkg.
module mftt_table #(
    parameter int MOTORS_PER_BUS = 11,
    parameter int BUS_COUNT      = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [((BUS_COUNT > 2 ? 2 : BUS_COUNT) * MOTORS_PER_BUS > 1 ?
                   $clog2((BUS_COUNT > 2 ? 2 : BUS_COUNT) * MOTORS_PER_BUS) : 1) - 1:0]
                                                 i_index,
    input  logic [mftt_pkg::DATA_W-1:0]          i_angle,
    input  logic signed [mftt_pkg::DATA_W-1:0]   i_speed,
    input  logic [mftt_pkg::THR_W-1:0]           i_threshold,
    output logic signed [mftt_pkg::DELTA_W-1:0]  o_delta,
    output logic signed [mftt_pkg::COUNT_W-1:0]  o_count
);

    localparam int EFF_BUS = (BUS_COUNT > 2) ? 2 : BUS_COUNT;
    localparam int ENTRIES = EFF_BUS * MOTORS_PER_BUS;

    logic [mftt_pkg::DATA_W-1:0]  r_last_angle [ENTRIES];
    logic [mftt_pkg::COUNT_W-1:0] r_turns      [ENTRIES];

    logic [mftt_pkg::DATA_W-1:0]  prev_angle;
    logic [mftt_pkg::COUNT_W-1:0] prev_count;
    logic signed [mftt_pkg::DELTA_W-1:0] delta;
    logic signed [mftt_pkg::DELTA_W-1:0] spd_x;
    logic signed [mftt_pkg::DELTA_W-1:0] thr_x;
    logic [mftt_pkg::COUNT_W-1:0] n_count;

    // Read the entry, form the delta and apply the turn rule
    always_comb begin
        prev_angle = r_last_angle[i_index];
        prev_count = r_turns[i_index];
        delta      = $signed({1'b0, i_angle}) - $signed({1'b0, prev_angle});
        spd_x      = {i_speed[mftt_pkg::DATA_W-1], i_speed};
        thr_x      = $signed({2'b00, i_threshold});
        n_count    = prev_count;
        if (spd_x < -thr_x) begin
            if (delta > 0) begin
                n_count = prev_count - 32'd1;
            end
        end else if (spd_x > thr_x) begin
            if (delta < 0) begin
                n_count = prev_count + 32'd1;
            end
        end
    end

    // Write back the entry; clear the whole table at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_last_angle[k] <= '0;
                r_turns[k]      <= '0;
            end
        end else if (i_we) begin
            r_last_angle[i_index] <= i_angle;
            r_turns[i_index]      <= n_count;
        end
    end

    assign o_delta = delta;
    assign o_count = $signed(n_count);

endmodule

FILE: src/motor_feedback_turn_tracker_core.sv
// Top level of the motor feedback turn tracker: handshakes, threshold
// register and result register. Depends on mftt_pkg, mftt_decode, mftt_table.
//
// Use:
//   Input channel (i_in_valid / o_in_ready) takes one received feedback
//   frame: bus, 11-bit identifier and six data bytes. Frames with an
//   identifier outside 0x201 .. 0x200 + MOTORS_PER_BUS, or on a bus that
//   is not fitted, are dropped without a result.
//   Output channel (o_out_valid / i_out_ready) gives one item per kept
//   frame: decoded angle, speed, current, the angle delta against the
//   previous frame of that motor and the updated multi-turn count.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the 15-bit speed
//   threshold; it is always ready. Write it only while no item is in flight.
// Timing:
//   An accepted frame passes the input register, then the table
//   read-modify-write into the result register. Throughput is one item
//   per cycle while the receiver takes results; the table updates one
//   entry per item.
// Reset clears the table (angles and counts to zero), the threshold to 100
// and both pipeline stages. When the receiver stalls, the result register
// holds and the input register still takes one more item before
// o_in_ready drops.
module motor_feedback_turn_tracker_core #(
    parameter int MOTORS_PER_BUS = 11,
    parameter int BUS_COUNT      = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_bus_select,
    input  logic [10:0]                         i_frame_id,
    input  logic [7:0]                          i_angle_high,
    input  logic [7:0]                          i_angle_low,
    input  logic [7:0]                          i_speed_high,
    input  logic [7:0]                          i_speed_low,
    input  logic [7:0]                          i_current_high,
    input  logic [7:0]                          i_current_low,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_out_bus,
    output logic [mftt_pkg::SLOT_W-1:0]         o_motor_index,
    output logic [mftt_pkg::DATA_W-1:0]         o_angle,
    output logic signed [mftt_pkg::DATA_W-1:0]  o_speed,
    output logic signed [mftt_pkg::DATA_W-1:0]  o_current,
    output logic signed [mftt_pkg::DELTA_W-1:0] o_angle_delta,
    output logic signed [mftt_pkg::COUNT_W-1:0] o_turn_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mftt_pkg::THR_W-1:0]          i_cfg_data
);

    localparam int EFF_BUS = (BUS_COUNT > 2) ? 2 : BUS_COUNT;
    localparam int ENTRIES = EFF_BUS * MOTORS_PER_BUS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [mftt_pkg::THR_W-1:0]          r_threshold;
    logic                                r_out_valid;
    mftt_pkg::t_frame                    r_out_frame;
    logic signed [mftt_pkg::DELTA_W-1:0] r_out_delta;
    logic signed [mftt_pkg::COUNT_W-1:0] r_out_count;

    logic                                stage_valid;
    mftt_pkg::t_frame                    stage_frame;
    logic [IDX_W-1:0]                    stage_index;
    logic                                advance;
    logic                                load;
    logic signed [mftt_pkg::DELTA_W-1:0] delta;
    logic signed [mftt_pkg::COUNT_W-1:0] count;

    // Advance when the result register is free or being emptied
    assign advance    = stage_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !stage_valid || advance;
    assign load       = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    mftt_decode #(
        .MOTORS_PER_BUS (MOTORS_PER_BUS),
        .BUS_COUNT      (BUS_COUNT)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_advance      (advance),
        .i_bus_select   (i_bus_select),
        .i_frame_id     (i_frame_id),
        .i_angle_high   (i_angle_high),
        .i_angle_low    (i_angle_low),
        .i_speed_high   (i_speed_high),
        .i_speed_low    (i_speed_low),
        .i_current_high (i_current_high),
        .i_current_low  (i_current_low),
        .o_valid        (stage_valid),
        .o_frame        (stage_frame),
        .o_index        (stage_index)
    );

    mftt_table #(
        .MOTORS_PER_BUS (MOTORS_PER_BUS),
        .BUS_COUNT      (BUS_COUNT)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (advance),
        .i_index     (stage_index),
        .i_angle     (stage_frame.angle),
        .i_speed     (stage_frame.speed),
        .i_threshold (r_threshold),
        .o_delta     (delta),
        .o_count     (count)
    );

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= mftt_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Result valid: set on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_frame <= stage_frame;
            r_out_delta <= delta;
            r_out_count <= count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_bus     = r_out_frame.bus;
    assign o_motor_index = r_out_frame.slot;
    assign o_angle       = r_out_frame.angle;
    assign o_speed       = r_out_frame.speed;
    assign o_current     = r_out_frame.current;
    assign o_angle_delta = r_out_delta;
    assign o_turn_count  = r_out_count;

    // Input side only backs up while an item sits in the input register
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> stage_valid)
        else $error("input ready low with empty input register");

    // Every result names a fitted motor slot and bus
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_motor_index) < MOTORS_PER_BUS)
                        && (32'(o_out_bus) < BUS_COUNT))
        else $error("result for a slot or bus that is not fitted");

    // Nothing is shown in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
